// File: rtl/mmx_pkg.sv
// ----------------------------------------------------------------------------
// mmx_pkg: shared types and constants of the plus-frame motor mixer
// Field widths, register indexes, reset values and lane control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package mmx_pkg;

  localparam int LANES    = 4;   // one lane per motor
  localparam int FIELD_W  = 32;  // input and result fields
  localparam int GAIN_W   = 24;  // Q8.16 gains
  localparam int COEFF_W  = 32;  // inverse thrust coefficient
  localparam int ADDR_W   = 8;
  localparam int PROD_W   = 57;  // 32b signed times 24b unsigned
  localparam int SUM_W    = 58;  // three products summed
  localparam int MAG_W    = 41;  // |sum| >> 16
  localparam int MLO_W    = 32;  // low part of the magnitude into the multiplier
  localparam int MHI_W    = MAG_W - MLO_W;
  localparam int PHI_W    = MHI_W + COEFF_W;
  localparam int PFULL_W  = MAG_W + COEFF_W;
  localparam int RAD_W    = 62;  // radicand below the saturation bound
  localparam int ROOT_W   = 31;
  localparam int REM_W    = 33;
  localparam int STEPS    = RAD_W / 2;
  localparam int CNT_W    = 5;

  // register indexes
  localparam logic [ADDR_W-1:0] REG_THRUST_SHARE = 8'd0;
  localparam logic [ADDR_W-1:0] REG_TORQUE_SHARE = 8'd1;
  localparam logic [ADDR_W-1:0] REG_YAW_SHARE    = 8'd2;
  localparam logic [ADDR_W-1:0] REG_INV_COEFF    = 8'd3;

  localparam logic [GAIN_W-1:0]  THRUST_SHARE_RST = 24'd16384;
  localparam logic [GAIN_W-1:0]  TORQUE_SHARE_RST = 24'd231704;
  localparam logic [GAIN_W-1:0]  YAW_SHARE_RST    = 24'd16384;
  localparam logic [COEFF_W-1:0] INV_COEFF_RST    = 32'd100000;

  localparam logic [FIELD_W-1:0] VEL_POS_SAT = 32'h7FFF_FFFF;
  localparam logic [FIELD_W-1:0] VEL_NEG_SAT = 32'h8000_0000;

  // lane order matches the result order
  localparam int LANE_LEFT  = 0;
  localparam int LANE_FRONT = 1;
  localparam int LANE_RIGHT = 2;
  localparam int LANE_BACK  = 3;

  typedef logic signed [SUM_W-1:0] mix_sum_t;

  typedef enum logic [2:0] {
    LN_IDLE,
    LN_MUL_LO,
    LN_MUL_HI,
    LN_SUM,
    LN_ROOT,
    LN_DONE
  } lane_state_t;

  typedef struct packed {
    logic prod_load;
    logic sum_load;
  } mix_ctrl_t;

  typedef struct packed {
    logic start;
    logic take;
  } lane_ctrl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } lane_stat_t;

endpackage

`default_nettype wire

// File: rtl/mmx_if.sv
// ----------------------------------------------------------------------------
// mmx_if: channel interfaces of the motor mixer
// Control vector input, velocity result output and register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface mmx_in_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] collective_thrust;
  logic signed [31:0] roll_torque;
  logic signed [31:0] pitch_torque;
  logic signed [31:0] yaw_torque;

  modport source (output valid, output collective_thrust, output roll_torque,
                  output pitch_torque, output yaw_torque, input ready);
  modport sink   (input valid, input collective_thrust, input roll_torque,
                  input pitch_torque, input yaw_torque, output ready);
endinterface

interface mmx_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] left_velocity;
  logic signed [31:0] front_velocity;
  logic signed [31:0] right_velocity;
  logic signed [31:0] back_velocity;

  modport source (output valid, output left_velocity, output front_velocity,
                  output right_velocity, output back_velocity, input ready);
  modport sink   (input valid, input left_velocity, input front_velocity,
                  input right_velocity, input back_velocity, output ready);
endinterface

interface mmx_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  addr;
  logic [31:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/quad_motor_mixer_sqrt.sv
// ----------------------------------------------------------------------------
// quad_motor_mixer_sqrt: plus-frame quadcopter motor mixer
// Mixes thrust and torques into four motor thrusts and converts each into
// a signed Q24.8 velocity in four parallel square-root lanes.
// ----------------------------------------------------------------------------
// The lanes limit the flow: each item holds them for the 31-step root loop
//   plus the two multiply passes; input buffer, mix stages and output
//   register overlap neighboring items.
// Reset: synchronous active-low rst_n clears all valids and lane state and
//   loads the register defaults; the block is ready right after reset.
`default_nettype none

module quad_motor_mixer_sqrt (
  input  wire        clk,
  input  wire        rst_n,
  mmx_in_if.sink     in_ch,
  mmx_out_if.source  out_ch,
  mmx_cfg_if.sink    cfg_ch
);

  logic [mmx_pkg::GAIN_W-1:0]  thrust_share_r, torque_share_r, yaw_share_r;
  logic [mmx_pkg::COEFF_W-1:0] inv_coeff_r;

  logic                               buf_valid_r, prod_valid_r, sum_valid_r;
  logic                               out_valid_r;
  logic signed [mmx_pkg::FIELD_W-1:0] thrust_r, roll_r, pitch_r, yaw_r;
  logic [mmx_pkg::FIELD_W-1:0]        vel_r [mmx_pkg::LANES];

  mmx_pkg::mix_ctrl_t  mix_ctrl;
  mmx_pkg::lane_ctrl_t lane_ctrl;
  mmx_pkg::lane_stat_t lane_stat [mmx_pkg::LANES];
  mmx_pkg::mix_sum_t   sums [mmx_pkg::LANES];
  logic [mmx_pkg::FIELD_W-1:0] vel [mmx_pkg::LANES];
  logic [mmx_pkg::LANES-1:0]   lane_idle, lane_done;

  logic in_xfer, buf_adv, prod_adv, prod_free, sum_free;

  // configuration
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thrust_share_r <= mmx_pkg::THRUST_SHARE_RST;
      torque_share_r <= mmx_pkg::TORQUE_SHARE_RST;
      yaw_share_r    <= mmx_pkg::YAW_SHARE_RST;
      inv_coeff_r    <= mmx_pkg::INV_COEFF_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        mmx_pkg::REG_THRUST_SHARE: thrust_share_r <= cfg_ch.data[mmx_pkg::GAIN_W-1:0];
        mmx_pkg::REG_TORQUE_SHARE: torque_share_r <= cfg_ch.data[mmx_pkg::GAIN_W-1:0];
        mmx_pkg::REG_YAW_SHARE:    yaw_share_r    <= cfg_ch.data[mmx_pkg::GAIN_W-1:0];
        mmx_pkg::REG_INV_COEFF:    inv_coeff_r    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // pipeline flow: input buffer -> products -> sums -> lanes -> output
  always_comb begin
    for (int i = 0; i < mmx_pkg::LANES; i++) begin
      lane_idle[i] = lane_stat[i].idle;
      lane_done[i] = lane_stat[i].done;
    end
  end

  assign in_ch.ready     = !buf_valid_r;
  assign in_xfer         = in_ch.valid && !buf_valid_r;
  assign lane_ctrl.start = sum_valid_r && (&lane_idle);
  assign lane_ctrl.take  = (&lane_done) && (!out_valid_r || out_ch.ready);
  assign sum_free        = !sum_valid_r || lane_ctrl.start;
  assign prod_adv        = prod_valid_r && sum_free;
  assign prod_free       = !prod_valid_r || prod_adv;
  assign buf_adv         = buf_valid_r && prod_free;
  assign mix_ctrl.prod_load = buf_adv;
  assign mix_ctrl.sum_load  = prod_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r  <= 1'b0;
      prod_valid_r <= 1'b0;
      sum_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_xfer) begin
        buf_valid_r <= 1'b1;
      end else if (buf_adv) begin
        buf_valid_r <= 1'b0;
      end
      if (buf_adv) begin
        prod_valid_r <= 1'b1;
      end else if (prod_adv) begin
        prod_valid_r <= 1'b0;
      end
      if (prod_adv) begin
        sum_valid_r <= 1'b1;
      end else if (lane_ctrl.start) begin
        sum_valid_r <= 1'b0;
      end
      if (lane_ctrl.take) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      thrust_r <= in_ch.collective_thrust;
      roll_r   <= in_ch.roll_torque;
      pitch_r  <= in_ch.pitch_torque;
      yaw_r    <= in_ch.yaw_torque;
    end
    if (lane_ctrl.take) begin
      vel_r <= vel;
    end
  end

  mmx_mix u_mix (
    .clk    (clk),
    .ctrl   (mix_ctrl),
    .thrust (thrust_r),
    .roll   (roll_r),
    .pitch  (pitch_r),
    .yaw    (yaw_r),
    .gain_a (thrust_share_r),
    .gain_b (torque_share_r),
    .gain_c (yaw_share_r),
    .sum    (sums)
  );

  for (genvar g = 0; g < mmx_pkg::LANES; g++) begin : g_lane
    mmx_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (lane_ctrl),
      .sum      (sums[g]),
      .coeff    (inv_coeff_r),
      .stat     (lane_stat[g]),
      .velocity (vel[g])
    );
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.left_velocity  = vel_r[mmx_pkg::LANE_LEFT];
  assign out_ch.front_velocity = vel_r[mmx_pkg::LANE_FRONT];
  assign out_ch.right_velocity = vel_r[mmx_pkg::LANE_RIGHT];
  assign out_ch.back_velocity  = vel_r[mmx_pkg::LANE_BACK];

endmodule

`default_nettype wire

// File: rtl/mmx_mix.sv
// ----------------------------------------------------------------------------
// mmx_mix: gain products and plus-frame motor sums
// One register stage of four products, then one stage of four exact sums.
// ----------------------------------------------------------------------------
`default_nettype none

module mmx_mix (
  input  wire                                clk,
  input  mmx_pkg::mix_ctrl_t                 ctrl,
  input  wire  signed [mmx_pkg::FIELD_W-1:0] thrust,
  input  wire  signed [mmx_pkg::FIELD_W-1:0] roll,
  input  wire  signed [mmx_pkg::FIELD_W-1:0] pitch,
  input  wire  signed [mmx_pkg::FIELD_W-1:0] yaw,
  input  wire         [mmx_pkg::GAIN_W-1:0]  gain_a,
  input  wire         [mmx_pkg::GAIN_W-1:0]  gain_b,
  input  wire         [mmx_pkg::GAIN_W-1:0]  gain_c,
  output mmx_pkg::mix_sum_t                  sum [mmx_pkg::LANES]
);

  logic signed [mmx_pkg::PROD_W-1:0] at_r, br_r, bp_r, cy_r;
  mmx_pkg::mix_sum_t                 sum_r [mmx_pkg::LANES];
  mmx_pkg::mix_sum_t                 at_x, br_x, bp_x, cy_x;

  // gains are unsigned: a zero top bit keeps them positive in signed math
  always_ff @(posedge clk) begin
    if (ctrl.prod_load) begin
      at_r <= thrust * $signed({1'b0, gain_a});
      br_r <= roll   * $signed({1'b0, gain_b});
      bp_r <= pitch  * $signed({1'b0, gain_b});
      cy_r <= yaw    * $signed({1'b0, gain_c});
    end
  end

  assign at_x = mmx_pkg::SUM_W'(at_r);
  assign br_x = mmx_pkg::SUM_W'(br_r);
  assign bp_x = mmx_pkg::SUM_W'(bp_r);
  assign cy_x = mmx_pkg::SUM_W'(cy_r);

  always_ff @(posedge clk) begin
    if (ctrl.sum_load) begin
      sum_r[mmx_pkg::LANE_LEFT]  <= at_x + bp_x + cy_x;
      sum_r[mmx_pkg::LANE_FRONT] <= at_x + br_x - cy_x;
      sum_r[mmx_pkg::LANE_RIGHT] <= at_x - bp_x + cy_x;
      sum_r[mmx_pkg::LANE_BACK]  <= at_x - br_x - cy_x;
    end
  end

  assign sum = sum_r;

endmodule

`default_nettype wire

// File: rtl/mmx_lane.sv
// ----------------------------------------------------------------------------
// mmx_lane: thrust-to-velocity lane
// Scales |sum| by the coefficient with a shared 32x32 multiplier in two
// passes, then takes a floor square root two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mmx_lane (
  input  wire                                clk,
  input  wire                                rst_n,
  input  mmx_pkg::lane_ctrl_t                ctrl,
  input  mmx_pkg::mix_sum_t                  sum,
  input  wire         [mmx_pkg::COEFF_W-1:0] coeff,
  output mmx_pkg::lane_stat_t                stat,
  output logic        [mmx_pkg::FIELD_W-1:0] velocity
);

  mmx_pkg::lane_state_t state_r, state_nxt;

  logic                          neg_r;
  logic [mmx_pkg::MAG_W-1:0]     m_r;
  logic [2*mmx_pkg::MLO_W-1:0]   prod_lo_r;
  logic [mmx_pkg::PHI_W-1:0]     prod_hi_r;
  logic                          sat_r;
  logic [mmx_pkg::RAD_W-1:0]     rad_r;
  logic [mmx_pkg::REM_W-1:0]     rem_r;
  logic [mmx_pkg::ROOT_W-1:0]    root_r;
  logic [mmx_pkg::CNT_W-1:0]     cnt_r;

  logic [mmx_pkg::MLO_W-1:0]     mul_a;
  logic [2*mmx_pkg::MLO_W-1:0]   mul_p;
  mmx_pkg::mix_sum_t             mag;
  logic [mmx_pkg::PFULL_W-1:0]   p_full;
  logic [mmx_pkg::REM_W+1:0]     rem_sh;
  logic [mmx_pkg::REM_W+1:0]     trial;
  logic                          ge;
  logic [mmx_pkg::FIELD_W-1:0]   root_ext;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mmx_pkg::LN_IDLE:   if (ctrl.start) state_nxt = mmx_pkg::LN_MUL_LO;
      mmx_pkg::LN_MUL_LO: state_nxt = mmx_pkg::LN_MUL_HI;
      mmx_pkg::LN_MUL_HI: state_nxt = mmx_pkg::LN_SUM;
      mmx_pkg::LN_SUM:    state_nxt = mmx_pkg::LN_ROOT;
      mmx_pkg::LN_ROOT:   if (cnt_r == '0) state_nxt = mmx_pkg::LN_DONE;
      mmx_pkg::LN_DONE:   if (ctrl.take) state_nxt = mmx_pkg::LN_IDLE;
      default:            state_nxt = mmx_pkg::LN_IDLE;
    endcase
  end

  always_comb begin
    stat.idle = (state_r == mmx_pkg::LN_IDLE);
    stat.done = (state_r == mmx_pkg::LN_DONE);
    case (state_r)
      mmx_pkg::LN_MUL_HI: mul_a = {{(mmx_pkg::MLO_W-mmx_pkg::MHI_W){1'b0}},
                                   m_r[mmx_pkg::MAG_W-1:mmx_pkg::MLO_W]};
      default:            mul_a = m_r[mmx_pkg::MLO_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mmx_pkg::LN_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign mag    = sum[mmx_pkg::SUM_W-1] ? -sum : sum;
  assign mul_p  = mul_a * coeff;
  assign p_full = {prod_hi_r, {mmx_pkg::MLO_W{1'b0}}}
                + {{(mmx_pkg::PFULL_W-2*mmx_pkg::MLO_W){1'b0}}, prod_lo_r};
  assign rem_sh = {rem_r, rad_r[mmx_pkg::RAD_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    case (state_r)
      mmx_pkg::LN_IDLE: begin
        neg_r <= sum[mmx_pkg::SUM_W-1];
        m_r   <= mag[16 +: mmx_pkg::MAG_W];
      end
      mmx_pkg::LN_MUL_LO: prod_lo_r <= mul_p;
      mmx_pkg::LN_MUL_HI: prod_hi_r <= mul_p[mmx_pkg::PHI_W-1:0];
      mmx_pkg::LN_SUM: begin
        // product at or above 2^62 saturates the root
        sat_r  <= |p_full[mmx_pkg::PFULL_W-1:mmx_pkg::RAD_W];
        rad_r  <= p_full[mmx_pkg::RAD_W-1:0];
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= mmx_pkg::CNT_W'(mmx_pkg::STEPS - 1);
      end
      mmx_pkg::LN_ROOT: begin
        rem_r  <= ge ? mmx_pkg::REM_W'(rem_sh - trial) : rem_sh[mmx_pkg::REM_W-1:0];
        root_r <= {root_r[mmx_pkg::ROOT_W-2:0], ge};
        rad_r  <= {rad_r[mmx_pkg::RAD_W-3:0], 2'b00};
        cnt_r  <= cnt_r - 1'b1;
      end
      default: ;
    endcase
  end

  assign root_ext = {1'b0, root_r};

  always_comb begin
    if (sat_r) begin
      velocity = neg_r ? mmx_pkg::VEL_NEG_SAT : mmx_pkg::VEL_POS_SAT;
    end else begin
      velocity = neg_r ? -root_ext : root_ext;
    end
  end

endmodule

`default_nettype wire
